// ----- rtl/core/prl_pkg.sv -----
// Shared types, constants and helper functions of the press rate limiter.
package prl_pkg;

  localparam int unsigned CODE_W     = 3;
  localparam int unsigned EVT_TIME_W = 32;
  localparam int unsigned RATE_W     = 5;
  localparam int unsigned TPS_W      = 30;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_CH     = 2;

  localparam logic [CODE_W-1:0] BTN_LEFT  = 3'd1;
  localparam logic [CODE_W-1:0] BTN_RIGHT = 3'd2;

  localparam logic [RATE_W-1:0] RATE_MIN = 5'd1;
  localparam logic [RATE_W-1:0] RATE_MAX = 5'd30;
  localparam logic [TPS_W-1:0]  TPS_MIN  = 30'd1000;
  localparam logic [TPS_W-1:0]  TPS_MAX  = 30'd1000000000;
  localparam logic [TPS_W-1:0]  TPS_RST  = 30'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE     = 3'd0,
    REG_LEFT_ON    = 3'd1,
    REG_LEFT_RATE  = 3'd2,
    REG_RIGHT_ON   = 3'd3,
    REG_RIGHT_RATE = 3'd4,
    REG_TPS        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [TPS_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TPS_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
    logic [RATE_W-1:0] r;
    r = v;
    if (v < RATE_MIN) r = RATE_MIN;
    if (v > RATE_MAX) r = RATE_MAX;
    return r;
  endfunction

  function automatic logic [TPS_W-1:0] clamp_tps(input logic [TPS_W-1:0] v);
    logic [TPS_W-1:0] r;
    r = v;
    if (v < TPS_MIN) r = TPS_MIN;
    if (v > TPS_MAX) r = TPS_MAX;
    return r;
  endfunction

endpackage

// ----- rtl/core/prl_intf.sv -----
// Handshake interfaces for the event, result and register write channels.
interface prl_evt_if import prl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CODE_W-1:0]     button_code;
  logic                  pressed;
  logic [EVT_TIME_W-1:0] event_time;

  modport source (output valid, button_code, pressed, event_time, input ready);
  modport sink (input valid, button_code, pressed, event_time, output ready);
endinterface

interface prl_res_if;
  logic valid;
  logic ready;
  logic swallow;

  modport source (output valid, swallow, input ready);
  modport sink (input valid, swallow, output ready);
endinterface

interface prl_cfg_if import prl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/prl_div.sv -----
// Iterative restoring divider: one quotient bit per cycle for the press interval.
module prl_div import prl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(TPS_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TPS_W-1:0]  dvd_q;
  logic [RATE_W-1:0] dsr_q;
  logic [RATE_W:0]   rem_q;
  logic [RATE_W:0]   rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem_q[RATE_W-1:0], dvd_q[TPS_W-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(TPS_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // The dividend register shifts out numerator bits and shifts in quotient bits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_q <= {dvd_q[TPS_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

// ----- rtl/core/press_rate_limiter_unit.sv -----
// Releases, repeated presses, unlimited presses and other codes pass from the accept step through
// the decision step to the finish step, which registers the result.
// A limited press first prunes aged log entries, with a read and a check step per entry, and is then
// checked: it is swallowed there, or forwarded once the interval divider started beside it is done.
// One request is in flight at a time; the next is taken while its result waits.
// Reset restores register defaults and clears channel state; the log memory is not cleared.
module press_rate_limiter_unit import prl_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 32,
  parameter int unsigned TIME_BITS = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  prl_evt_if.sink     evt_i,
  prl_res_if.source   res_o,
  prl_cfg_if.sink     cfg_i
);

  localparam int unsigned IW        = $clog2(LOG_DEPTH);
  localparam int unsigned CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int unsigned CW        = (TIME_BITS > TPS_W) ? TIME_BITS : TPS_W;
  localparam int unsigned MEM_DEPTH = 2 ** (IW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_CHECK,
    ST_WAIT_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic                 active_q;
  logic [NUM_CH-1:0]    limit_on_q;
  logic [RATE_W-1:0]    rate_q [NUM_CH];
  logic [TPS_W-1:0]     tps_q;

  logic [NUM_CH-1:0]    held_q;
  logic [NUM_CH-1:0]    passed_q;
  logic [NUM_CH-1:0]    nvalid_q;
  logic [TIME_BITS-1:0] next_q [NUM_CH];
  logic [IW-1:0]        head_q [NUM_CH];
  logic [CNT_W-1:0]     cnt_q  [NUM_CH];

  logic [CODE_W-1:0]    code_q;
  logic                 press_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 ch_q;
  logic                 sw_q;
  logic                 res_valid_q;
  logic                 res_swallow_q;

  logic [TIME_BITS-1:0] mem [MEM_DEPTH];
  logic [TIME_BITS-1:0] rd_data_q;

  logic                 is_left;
  logic                 is_right;
  logic                 ch_sel;
  logic                 chan_lim;
  logic [CNT_W-1:0]     cur_cnt;
  logic [IW-1:0]        cur_head;
  logic [IW-1:0]        head_nxt;
  logic [CNT_W:0]       tail_sum;
  logic [IW-1:0]        tail_idx;
  logic [TIME_BITS-1:0] age;
  logic                 aged;
  logic [TIME_BITS-1:0] spacing;
  logic                 early;
  logic                 over;
  logic [TIME_BITS-1:0] next_val;
  logic                 mem_we;
  logic [IW:0]          mem_waddr;
  logic [IW:0]          mem_raddr;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  always_comb begin
    is_left  = code_q == BTN_LEFT;
    is_right = code_q == BTN_RIGHT;
    ch_sel   = is_right;
    chan_lim = limit_on_q[ch_sel] && active_q;

    cur_cnt  = cnt_q[ch_q];
    cur_head = head_q[ch_q];
    head_nxt = (cur_head == IW'(LOG_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    tail_sum = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_cnt);
    tail_idx = (tail_sum >= (CNT_W + 1)'(LOG_DEPTH)) ?
               IW'(tail_sum - (CNT_W + 1)'(LOG_DEPTH)) : IW'(tail_sum);

    // Wrapping differences keep the window and spacing checks valid across timer rollover.
    age      = now_q - rd_data_q;
    aged     = CW'(age) >= CW'(tps_q);
    spacing  = now_q - next_q[ch_q];
    early    = nvalid_q[ch_q] && spacing[TIME_BITS-1];
    over     = cur_cnt >= CNT_W'(rate_q[ch_q]);
    next_val = TIME_BITS'(CW'(now_q) + CW'(div_rsp.quot));

    mem_we    = (state_q == ST_WAIT_DIV) && div_rsp.done && (cur_cnt < CNT_W'(LOG_DEPTH));
    mem_waddr = {ch_q, tail_idx};
    mem_raddr = {ch_q, cur_head};

    div_req.start    = (state_q == ST_DECIDE) && press_q && (is_left || is_right) &&
                       !held_q[ch_sel] && chan_lim;
    div_req.dividend = tps_q;
    div_req.divisor  = rate_q[ch_sel];
  end

  prl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= now_q;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_q      <= 1'b0;
      limit_on_q    <= '0;
      rate_q[0]     <= RATE_MAX;
      rate_q[1]     <= RATE_MAX;
      tps_q         <= TPS_RST;
      held_q        <= '0;
      passed_q      <= '0;
      nvalid_q      <= '0;
      next_q[0]     <= '0;
      next_q[1]     <= '0;
      head_q[0]     <= '0;
      head_q[1]     <= '0;
      cnt_q[0]      <= '0;
      cnt_q[1]      <= '0;
      code_q        <= '0;
      press_q       <= 1'b0;
      now_q         <= '0;
      ch_q          <= 1'b0;
      sw_q          <= 1'b0;
      res_valid_q   <= 1'b0;
      res_swallow_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (evt_i.valid) begin
            code_q  <= evt_i.button_code;
            press_q <= evt_i.pressed;
            now_q   <= TIME_BITS'(evt_i.event_time);
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          ch_q <= ch_sel;
          if (!(is_left || is_right)) begin
            sw_q    <= 1'b0;
            state_q <= ST_FINISH;
          end else if (press_q) begin
            if (held_q[ch_sel]) begin
              sw_q    <= !passed_q[ch_sel];
              state_q <= ST_FINISH;
            end else begin
              held_q[ch_sel] <= 1'b1;
              if (!chan_lim) begin
                passed_q[ch_sel] <= 1'b1;
                sw_q             <= 1'b0;
                state_q          <= ST_FINISH;
              end else begin
                state_q <= ST_PRUNE_RD;
              end
            end
          end else begin
            if (held_q[ch_sel]) begin
              held_q[ch_sel]   <= 1'b0;
              passed_q[ch_sel] <= 1'b0;
              sw_q             <= !passed_q[ch_sel];
            end else begin
              sw_q <= 1'b0;
            end
            state_q <= ST_FINISH;
          end
        end
        ST_PRUNE_RD: begin
          state_q <= (cur_cnt == '0) ? ST_CHECK : ST_PRUNE_CHK;
        end
        ST_PRUNE_CHK: begin
          if (aged) begin
            head_q[ch_q] <= head_nxt;
            cnt_q[ch_q]  <= cur_cnt - 1'b1;
            state_q      <= ST_PRUNE_RD;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (early || over) begin
            passed_q[ch_q] <= 1'b0;
            sw_q           <= 1'b1;
            state_q        <= ST_FINISH;
          end else begin
            state_q <= ST_WAIT_DIV;
          end
        end
        ST_WAIT_DIV: begin
          if (div_rsp.done) begin
            passed_q[ch_q] <= 1'b1;
            nvalid_q[ch_q] <= 1'b1;
            next_q[ch_q]   <= next_val;
            if (cur_cnt < CNT_W'(LOG_DEPTH)) begin
              cnt_q[ch_q] <= cur_cnt + 1'b1;
            end
            sw_q    <= 1'b0;
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid_q || res_o.ready) begin
            res_swallow_q <= sw_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // The result slot is refilled from the finish step or freed by its handshake.
      if ((state_q == ST_FINISH) && (!res_valid_q || res_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_ACTIVE: begin
            active_q  <= cfg_i.data[0];
            held_q    <= '0;
            passed_q  <= '0;
            nvalid_q  <= '0;
            next_q[0] <= '0;
            next_q[1] <= '0;
            head_q[0] <= '0;
            head_q[1] <= '0;
            cnt_q[0]  <= '0;
            cnt_q[1]  <= '0;
          end
          REG_LEFT_ON:    limit_on_q[0] <= cfg_i.data[0];
          REG_LEFT_RATE:  rate_q[0]     <= clamp_rate(cfg_i.data[RATE_W-1:0]);
          REG_RIGHT_ON:   limit_on_q[1] <= cfg_i.data[0];
          REG_RIGHT_RATE: rate_q[1]     <= clamp_rate(cfg_i.data[RATE_W-1:0]);
          REG_TPS:        tps_q         <= clamp_tps(cfg_i.data[TPS_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  assign evt_i.ready   = state_q == ST_IDLE;
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = res_valid_q;
  assign res_o.swallow = res_swallow_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(LOG_DEPTH)) && (cnt_q[1] <= CNT_W'(LOG_DEPTH)))
    else $error("log count exceeds the log depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, head_q[0]} < (IW + 1)'(LOG_DEPTH)) && ({1'b0, head_q[1]} < (IW + 1)'(LOG_DEPTH)))
    else $error("log head out of range");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_i.valid && evt_i.ready) |=> (state_q == ST_DECIDE))
    else $error("accepted request did not enter the decision step");

  a_log_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !(cfg_i.valid && cfg_i.ready)) |=>
      (cnt_q[ch_q] == $past(cur_cnt) + 1'b1))
    else $error("logged press did not advance the log count");

endmodule

// ----- tb/press_rate_limiter_unit_test.sv -----
// Self-checking testbench for the press rate limiter unit.
`timescale 1ns / 100ps

module press_rate_limiter_unit_test;
  import prl_pkg::*;

  localparam int unsigned LOG_SLOTS     = 32;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 210;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned BACKLOG_SLOTS = 4096;

  // Register indexes that the block ignores.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // Button codes outside the two channels.
  localparam logic [CODE_W-1:0] BTN_OTHER_LO = 3'd0;
  localparam logic [CODE_W-1:0] BTN_OTHER_HI = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic                  pressed;
    logic [EVT_TIME_W-1:0] stamp;
  } button_evt_t;

  logic clk_i;
  logic rst_ni;

  prl_evt_if evt_if ();
  prl_res_if res_if ();
  prl_cfg_if cfg_if ();

  press_rate_limiter_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Pending requests and expected results, each kept as a list with read and write indexes.
  button_evt_t evt_backlog [BACKLOG_SLOTS];
  int          backlog_rd = 0;
  int          backlog_wr = 0;
  bit          swallow_expect [BACKLOG_SLOTS];
  int          expect_rd  = 0;
  int          expect_wr  = 0;

  int errors        = 0;
  int results_seen  = 0;
  int swallow_total = 0;
  int reg_writes    = 0;
  int settings_run  = 0;
  int quiet_cycles  = 0;
  bit idle_on       = 1'b1;
  bit calm          = 1'b0;

  // Mirror of the register file.
  bit                cfg_active;
  bit                cfg_left_on;
  logic [RATE_W-1:0] cfg_left_rate;
  bit                cfg_right_on;
  logic [RATE_W-1:0] cfg_right_rate;
  logic [TPS_W-1:0]  cfg_tps;

  // Mirror of the per-channel limiter state.
  bit                    btn_down [NUM_CH];
  bit                    press_fwd [NUM_CH];
  logic [EVT_TIME_W-1:0] next_ok_time [NUM_CH];
  bit                    next_ok_valid [NUM_CH];
  logic [EVT_TIME_W-1:0] press_times [NUM_CH][LOG_SLOTS];
  int                    log_first [NUM_CH];
  int                    log_fill [NUM_CH];

  // Stimulus generator state.
  logic [EVT_TIME_W-1:0] gen_time;
  bit                    gen_down [NUM_CH];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] v);
    if (v < 5'd1) return 5'd1;
    if (v > 5'd30) return 5'd30;
    return v;
  endfunction

  function automatic void clear_channels();
    for (int c = 0; c < NUM_CH; c++) begin
      btn_down[c]      = 1'b0;
      press_fwd[c]     = 1'b0;
      next_ok_time[c]  = '0;
      next_ok_valid[c] = 1'b0;
      log_first[c]     = 0;
      log_fill[c]      = 0;
      gen_down[c]      = 1'b0;
      for (int s = 0; s < LOG_SLOTS; s++) press_times[c][s] = '0;
    end
  endfunction

  function automatic bit predict_swallow(input logic [CODE_W-1:0] code, input logic pressed,
                                         input logic [EVT_TIME_W-1:0] now);
    int                    ch;
    bit                    limited;
    bit                    blocked;
    bit                    aging;
    logic [RATE_W-1:0]     rate;
    logic [EVT_TIME_W-1:0] age;
    logic [EVT_TIME_W-1:0] behind;
    logic [EVT_TIME_W-1:0] interval;
    if (code == BTN_LEFT) begin
      ch = 0;
      limited = cfg_left_on;
      rate = cfg_left_rate;
    end else if (code == BTN_RIGHT) begin
      ch = 1;
      limited = cfg_right_on;
      rate = cfg_right_rate;
    end else begin
      return 1'b0;
    end
    limited = limited && cfg_active;

    if (!pressed) begin
      if (!btn_down[ch]) return 1'b0;
      btn_down[ch] = 1'b0;
      blocked = !press_fwd[ch];
      press_fwd[ch] = 1'b0;
      return blocked;
    end

    if (btn_down[ch]) return !press_fwd[ch];
    btn_down[ch] = 1'b1;
    if (!limited) begin
      press_fwd[ch] = 1'b1;
      return 1'b0;
    end

    // Drop log entries that are a full second old or more, oldest first.
    aging = 1'b1;
    while (aging && log_fill[ch] > 0) begin
      age = now - press_times[ch][log_first[ch]];
      if (age >= cfg_tps) begin
        log_first[ch] = (log_first[ch] + 1) % LOG_SLOTS;
        log_fill[ch]--;
      end else begin
        aging = 1'b0;
      end
    end

    behind = now - next_ok_time[ch];
    if ((next_ok_valid[ch] && behind[EVT_TIME_W-1]) || log_fill[ch] >= rate) begin
      press_fwd[ch] = 1'b0;
      return 1'b1;
    end

    interval = cfg_tps / rate;
    press_fwd[ch] = 1'b1;
    next_ok_time[ch] = now + interval;
    next_ok_valid[ch] = 1'b1;
    if (log_fill[ch] < LOG_SLOTS) begin
      press_times[ch][(log_first[ch] + log_fill[ch]) % LOG_SLOTS] = now;
      log_fill[ch]++;
    end
    return 1'b0;
  endfunction

  // Event driver: presents the oldest pending request and predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin : evt_driver
    button_evt_t taken;
    int          gap_left;
    if (!rst_ni) begin
      evt_if.valid       <= 1'b0;
      evt_if.button_code <= '0;
      evt_if.pressed     <= 1'b0;
      evt_if.event_time  <= '0;
      gap_left = 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        taken = evt_backlog[backlog_rd];
        backlog_rd++;
        swallow_expect[expect_wr] = predict_swallow(taken.code, taken.pressed, taken.stamp);
        expect_wr++;
      end
      if (!(evt_if.valid && !evt_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          evt_if.valid <= 1'b0;
        end else if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 3);
          evt_if.valid <= 1'b0;
        end else if (backlog_wr > backlog_rd) begin
          evt_if.valid       <= 1'b1;
          evt_if.button_code <= evt_backlog[backlog_rd].code;
          evt_if.pressed     <= evt_backlog[backlog_rd].pressed;
          evt_if.event_time  <= evt_backlog[backlog_rd].stamp;
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    bit want;
    int stall_left;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expect_wr == expect_rd) begin
          $display("%0t: result with nothing pending: expected none, actual swallow=%0b",
                   $time, res_if.swallow);
          errors++;
        end else begin
          want = swallow_expect[expect_rd];
          expect_rd++;
          results_seen++;
          if (want) swallow_total++;
          if (res_if.swallow !== want) begin
            $display("%0t: swallow mismatch: expected %0b, actual %0b",
                     $time, want, res_if.swallow);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic add_event(input logic [CODE_W-1:0] code, input logic pressed,
                           input logic [EVT_TIME_W-1:0] stamp);
    evt_backlog[backlog_wr] = '{code: code, pressed: pressed, stamp: stamp};
    backlog_wr++;
  endtask

  // Wait until every request has been taken and every result has come back.
  task automatic drain();
    while (backlog_wr != backlog_rd || evt_if.valid || expect_wr != expect_rd)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ACTIVE: begin
        cfg_active = value[0];
        clear_channels();
      end
      REG_LEFT_ON:    cfg_left_on = value[0];
      REG_LEFT_RATE:  cfg_left_rate = sat_rate(value[RATE_W-1:0]);
      REG_RIGHT_ON:   cfg_right_on = value[0];
      REG_RIGHT_RATE: cfg_right_rate = sat_rate(value[RATE_W-1:0]);
      REG_TPS: begin
        if (value[TPS_W-1:0] < 30'd1000) cfg_tps = 30'd1000;
        else if (value[TPS_W-1:0] > 30'd1000000000) cfg_tps = 30'd1000000000;
        else cfg_tps = value[TPS_W-1:0];
      end
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return CFG_DATA_W'(RATE_MIN);
      2: return CFG_DATA_W'(RATE_MAX);
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] value;
    if ($urandom_range(0, 3) != 0) begin
      value = $urandom();
      value[0] = ($urandom_range(0, 5) != 0);
      write_reg(REG_ACTIVE, value);
    end
    if ($urandom_range(0, 2) != 0) begin
      value = $urandom();
      value[0] = ($urandom_range(0, 4) != 0);
      write_reg(REG_LEFT_ON, value);
    end
    if ($urandom_range(0, 2) != 0) begin
      value = $urandom();
      value[0] = ($urandom_range(0, 4) != 0);
      write_reg(REG_RIGHT_ON, value);
    end
    if ($urandom_range(0, 2) != 0) write_reg(REG_LEFT_RATE, pick_rate());
    if ($urandom_range(0, 2) != 0) write_reg(REG_RIGHT_RATE, pick_rate());
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0: value = $urandom();
        1: value = CFG_DATA_W'(TPS_MIN);
        2: value = CFG_DATA_W'(TPS_MAX);
        3: value = $urandom_range(1000, 200000);
        default: value = $urandom_range(0, 999);
      endcase
      write_reg(REG_TPS, value);
    end
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
  endtask

  // Mostly press/release pairs per channel with random spacing, plus some noise.
  task automatic random_phase(input int n);
    int                    kind;
    int                    ch;
    logic                  pr;
    logic [CODE_W-1:0]     code;
    logic [EVT_TIME_W-1:0] step_max;
    step_max = cfg_tps / $urandom_range(10, 160);
    if (step_max == 0) step_max = 1;
    @(negedge clk_i);
    repeat (n) begin
      gen_time += $urandom_range(0, step_max);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        code = CODE_W'($urandom_range(0, 7));
        add_event(code, 1'($urandom_range(0, 1)), gen_time);
      end else if (kind < 11) begin
        code = $urandom_range(0, 1) ? BTN_LEFT : BTN_RIGHT;
        add_event(code, 1'($urandom_range(0, 1)), $urandom());
      end else begin
        ch = $urandom_range(0, 1);
        pr = !gen_down[ch];
        // Occasionally a repeated press or a release without a press.
        if ($urandom_range(0, 9) == 0) pr = ~pr;
        gen_down[ch] = pr;
        add_event(ch == 0 ? BTN_LEFT : BTN_RIGHT, pr, gen_time);
      end
    end
  endtask

  initial begin
    evt_if.valid       = 1'b0;
    evt_if.button_code = '0;
    evt_if.pressed     = 1'b0;
    evt_if.event_time  = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    rst_ni             = 1'b0;

    cfg_active     = 1'b0;
    cfg_left_on    = 1'b0;
    cfg_left_rate  = RATE_MAX;
    cfg_right_on   = 1'b0;
    cfg_right_rate = RATE_MAX;
    cfg_tps        = TPS_RST;
    clear_channels();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Block inactive after reset: other codes, stray release, repeated press.
    @(negedge clk_i);
    add_event(BTN_OTHER_LO, 1'b1, '0);
    add_event(BTN_OTHER_HI, 1'b0, '1);
    add_event(BTN_LEFT, 1'b0, 32'd5);
    add_event(BTN_LEFT, 1'b1, 32'd10);
    add_event(BTN_LEFT, 1'b1, 32'd11);
    drain();
    settings_run++;

    // Limiting on both channels; rate and window writes saturate.
    write_reg(REG_ACTIVE, '1);
    write_reg(REG_LEFT_ON, 32'd1);
    write_reg(REG_RIGHT_ON, 32'd1);
    write_reg(REG_LEFT_RATE, 32'd31);
    write_reg(REG_RIGHT_RATE, 32'd0);
    write_reg(REG_TPS, 32'd0);
    write_reg(REG_SPARE_LO, 32'h0000_0001);
    @(negedge clk_i);
    add_event(BTN_LEFT, 1'b1, 32'd100);
    add_event(BTN_LEFT, 1'b0, 32'd101);
    add_event(BTN_LEFT, 1'b1, 32'd110);
    add_event(BTN_LEFT, 1'b1, 32'd111);
    add_event(BTN_LEFT, 1'b0, 32'd112);
    add_event(BTN_RIGHT, 1'b1, 32'd100);
    add_event(BTN_RIGHT, 1'b0, 32'd101);
    drain();
    settings_run++;

    // Put three presses into the left log, then lower the rate below what it holds.
    write_reg(REG_ACTIVE, 32'd1);
    write_reg(REG_LEFT_RATE, 32'd30);
    @(negedge clk_i);
    add_event(BTN_LEFT, 1'b1, 32'd2000);
    add_event(BTN_LEFT, 1'b0, 32'd2001);
    add_event(BTN_LEFT, 1'b1, 32'd2034);
    add_event(BTN_LEFT, 1'b0, 32'd2035);
    add_event(BTN_LEFT, 1'b1, 32'd2068);
    add_event(BTN_LEFT, 1'b0, 32'd2069);
    drain();
    write_reg(REG_LEFT_RATE, 32'd1);
    @(negedge clk_i);
    add_event(BTN_LEFT, 1'b1, 32'd2102);
    add_event(BTN_LEFT, 1'b0, 32'd2103);
    add_event(BTN_LEFT, 1'b1, 32'd3070);
    add_event(BTN_LEFT, 1'b0, 32'd3071);
    drain();
    settings_run++;

    // Longest window and a spacing check across the time wrap.
    write_reg(REG_TPS, '1);
    write_reg(REG_ACTIVE, 32'd1);
    @(negedge clk_i);
    add_event(BTN_LEFT, 1'b1, 32'hFFFF_FFF0);
    add_event(BTN_LEFT, 1'b0, 32'hFFFF_FFF8);
    add_event(BTN_LEFT, 1'b1, 32'h0000_0010);
    drain();
    settings_run++;

    gen_time = $urandom();
    for (int p = 0; p < NUM_PHASES; p++) begin
      random_config();
      idle_on = ($urandom_range(0, 3) != 0);
      calm = (p == NUM_PHASES - 1);
      random_phase(PHASE_ITEMS);
      drain();
      settings_run++;
    end

    repeat (40) @(posedge clk_i);
    if (expect_wr != expect_rd) begin
      $display("%0t: %0d results never arrived", $time, expect_wr - expect_rd);
      errors++;
    end
    $display("Checked %0d button events, %0d of them swallowed, under %0d register settings.",
             results_seen, swallow_total, settings_run);
    $display("Register writes: %0d; mismatches: %0d.", reg_writes, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- press_rate_limiter_unit.f -----
rtl/core/prl_pkg.sv
rtl/core/prl_intf.sv
rtl/core/prl_div.sv
rtl/core/press_rate_limiter_unit.sv
tb/press_rate_limiter_unit_test.sv
